@@ sv/dle_pkg.sv @@
// dle_pkg: shared constants, codes and a control struct for the deque list engine
// used by dle_ctrl, dle_datapath, deque_list_engine_unit and its checker
package dle_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WIDTH_DEFAULT = 32;

   localparam logic [3:0] ACT_PUSH_FRONT   = 4'd0;
   localparam logic [3:0] ACT_PUSH_BACK    = 4'd1;
   localparam logic [3:0] ACT_POP_FRONT    = 4'd2;
   localparam logic [3:0] ACT_POP_BACK     = 4'd3;
   localparam logic [3:0] ACT_READ_AT      = 4'd4;
   localparam logic [3:0] ACT_REMOVE_AT    = 4'd5;
   localparam logic [3:0] ACT_INSERT_AT    = 4'd6;
   localparam logic [3:0] ACT_FIND_REMOVE  = 4'd7;
   localparam logic [3:0] ACT_ORDERED_INS  = 4'd8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request fields
      logic scan_rd;    // issue read of entry at scan index
      logic scan_step;  // advance scan index
      logic shift_rd;   // issue read for shift move
      logic shift_wr;   // write shifted entry, step shift index
      logic ins_wr;     // write new value at target
      logic end_rd;     // read front or back for refresh
      logic end_cap;    // capture end value
      logic res_cap;    // capture result value from read data
   } dle_cmd_type;

endpackage

@@ sv/dle_datapath.sv @@
// dle_datapath: entry memory, count, scan and shift indexes, result registers
// depends on dle_pkg; driven by dle_ctrl through plain command signals
module dle_datapath #(
   parameter int DEPTH = dle_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = dle_pkg::WIDTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic [WIDTH-1:0]     value,
   input  logic [CW-1:0]        idx_set,     // index to start scan or shift at
   input  logic                 idx_load,
   input  logic                 idx_inc,
   input  logic                 idx_dec,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   input  logic                 wr_en,
   input  logic                 wr_sel_val,  // write request value instead of read data
   input  logic [AW-1:0]        wr_addr,
   input  logic                 cnt_inc,
   input  logic                 cnt_dec,
   input  logic                 res_cap,
   input  logic                 res_clr,
   input  logic                 front_cap,
   input  logic                 back_cap,
   output logic [CW-1:0]        idx,
   output logic [CW-1:0]        cnt,
   output logic                 rd_eq,
   output logic                 rd_less,
   output logic [WIDTH-1:0]     res,
   output logic [WIDTH-1:0]     front,
   output logic [WIDTH-1:0]     back
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff, val_ff, res_ff, front_ff, back_ff;
   logic [CW-1:0]    idx_ff, cnt_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_sel_val ? val_ff : rd_ff;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
      if (load) begin
         val_ff <= value;
      end
      if (res_clr) begin
         res_ff <= '0;
      end else if (res_cap) begin
         res_ff <= rd_ff;
      end
      if (front_cap) begin
         front_ff <= rd_ff;
      end
      if (back_cap) begin
         back_ff <= rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (cnt_dec) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (idx_load) begin
            idx_ff <= idx_set;
         end else if (idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end else if (idx_dec) begin
            idx_ff <= idx_ff - 1'b1;
         end
      end
   end

   assign idx     = idx_ff;
   assign cnt     = cnt_ff;
   assign rd_eq   = (rd_ff == val_ff);
   assign rd_less = $signed(rd_ff) < $signed(val_ff);
   assign res     = res_ff;
   assign front   = (cnt_ff == '0) ? '0 : front_ff;
   assign back    = (cnt_ff == '0) ? '0 : back_ff;
endmodule

@@ sv/dle_ctrl.sv @@
// dle_ctrl: sequencer for one list operation at a time
// depends on dle_pkg; drives dle_datapath commands, owns the handshake
module dle_ctrl #(
   parameter int DEPTH = dle_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [3:0]     req_action,
   input  logic [4:0]     req_position,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [2:0]     rsp_status,
   input  logic [CW-1:0]  idx,
   input  logic [CW-1:0]  cnt,
   input  logic           rd_eq,
   input  logic           rd_less,
   output logic           load,
   output logic [CW-1:0]  idx_set,
   output logic           idx_load,
   output logic           idx_inc,
   output logic           idx_dec,
   output logic           rd_en,
   output logic [AW-1:0]  rd_addr,
   output logic           wr_en,
   output logic           wr_sel_val,
   output logic [AW-1:0]  wr_addr,
   output logic           cnt_inc,
   output logic           cnt_dec,
   output logic           res_cap,
   output logic           res_clr,
   output logic           front_cap,
   output logic           back_cap
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_FIND   = 4'd2;  // read idx
   localparam logic [3:0] S_FCHK   = 4'd3;  // compare read data
   localparam logic [3:0] S_RES    = 4'd4;  // read target for result
   localparam logic [3:0] S_RESC   = 4'd5;
   localparam logic [3:0] S_RMRD   = 4'd6;  // remove: read idx+1
   localparam logic [3:0] S_RMWR   = 4'd7;  // remove: write idx
   localparam logic [3:0] S_INRD   = 4'd8;  // insert: read idx-1
   localparam logic [3:0] S_INWR   = 4'd9;  // insert: write idx
   localparam logic [3:0] S_INPUT  = 4'd10; // write value at idx
   localparam logic [3:0] S_FRD    = 4'd11; // refresh front
   localparam logic [3:0] S_FCAP   = 4'd12;
   localparam logic [3:0] S_BCAP   = 4'd13;
   localparam logic [3:0] S_RSP    = 4'd14;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    act_ff;
   logic [4:0]    pos_ff;
   logic [2:0]    st_ff, st_in;
   logic [CW-1:0] tgt_ff, tgt_in;
   logic          find_ph_ff, find_ph_in; // 0 front/back probe, 1 middle scan
   logic          full, empty;
   logic [CW:0]   pos_x, cnt_x;

   assign full  = (cnt == CW'(DEPTH));
   assign empty = (cnt == '0);
   assign pos_x = (CW+1)'(pos_ff);
   assign cnt_x = (CW+1)'(cnt);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         st_ff      <= dle_pkg::ST_OK;
         tgt_ff     <= '0;
         find_ph_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         st_ff      <= st_in;
         tgt_ff     <= tgt_in;
         find_ph_ff <= find_ph_in;
      end
      if (load) begin
         act_ff <= req_action;
         pos_ff <= req_position;
      end
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign load       = req_valid && (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RSP);
   assign rsp_status = st_ff;

   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      tgt_in     = tgt_ff;
      find_ph_in = find_ph_ff;
      idx_set    = '0;
      idx_load   = 1'b0;
      idx_inc    = 1'b0;
      idx_dec    = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = AW'(idx);
      wr_en      = 1'b0;
      wr_sel_val = 1'b0;
      wr_addr    = AW'(idx);
      cnt_inc    = 1'b0;
      cnt_dec    = 1'b0;
      res_cap    = 1'b0;
      res_clr    = 1'b0;
      front_cap  = 1'b0;
      back_cap   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (load) begin
               res_clr  = 1'b1;
               st_in    = dle_pkg::ST_OK;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RSP;
            case (act_ff)
               dle_pkg::ACT_PUSH_FRONT, dle_pkg::ACT_PUSH_BACK,
               dle_pkg::ACT_INSERT_AT: begin
                  if (full) begin
                     st_in = dle_pkg::ST_FULL;
                  end else if (act_ff == dle_pkg::ACT_INSERT_AT && pos_x > cnt_x) begin
                     st_in = dle_pkg::ST_RANGE;
                  end else begin
                     tgt_in = (act_ff == dle_pkg::ACT_PUSH_FRONT) ? '0 :
                              (act_ff == dle_pkg::ACT_PUSH_BACK) ? cnt : CW'(pos_ff);
                     idx_set  = cnt;
                     idx_load = 1'b1;
                     state_in = S_INRD;
                  end
               end
               dle_pkg::ACT_POP_FRONT, dle_pkg::ACT_POP_BACK,
               dle_pkg::ACT_READ_AT, dle_pkg::ACT_REMOVE_AT: begin
                  if (empty) begin
                     st_in = dle_pkg::ST_EMPTY;
                  end else if ((act_ff == dle_pkg::ACT_READ_AT ||
                                act_ff == dle_pkg::ACT_REMOVE_AT) && pos_x >= cnt_x) begin
                     st_in = dle_pkg::ST_RANGE;
                  end else begin
                     idx_set  = (act_ff == dle_pkg::ACT_POP_FRONT) ? '0 :
                                (act_ff == dle_pkg::ACT_POP_BACK) ? cnt - 1'b1 : CW'(pos_ff);
                     idx_load = 1'b1;
                     state_in = S_RES;
                  end
               end
               dle_pkg::ACT_FIND_REMOVE: begin
                  if (empty) begin
                     st_in = dle_pkg::ST_NOTFOUND;
                  end else begin
                     find_ph_in = 1'b0;
                     idx_set    = '0;
                     idx_load   = 1'b1;
                     state_in   = S_FIND;
                  end
               end
               dle_pkg::ACT_ORDERED_INS: begin
                  if (full) begin
                     st_in = dle_pkg::ST_FULL;
                  end else begin
                     idx_set  = '0;
                     idx_load = 1'b1;
                     state_in = S_FIND;
                  end
               end
               default: begin
                  state_in = S_RSP;
               end
            endcase
         end
         S_FIND: begin
            if (act_ff == dle_pkg::ACT_ORDERED_INS && idx == cnt) begin
               // every entry smaller: append
               tgt_in   = cnt;
               idx_set  = cnt;
               idx_load = 1'b1;
               state_in = S_INRD;
            end else if (act_ff == dle_pkg::ACT_FIND_REMOVE && find_ph_ff &&
                         idx + 1'b1 >= cnt) begin
               st_in    = dle_pkg::ST_NOTFOUND;
               state_in = S_RSP;
            end else begin
               rd_en    = 1'b1;
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (act_ff == dle_pkg::ACT_ORDERED_INS) begin
               if (!rd_less) begin
                  tgt_in   = idx;
                  idx_set  = cnt;
                  idx_load = 1'b1;
                  state_in = S_INRD;
               end else begin
                  idx_inc  = 1'b1;
                  state_in = S_FIND;
               end
            end else if (rd_eq) begin
               res_cap  = 1'b1;
               tgt_in   = idx;
               state_in = S_RMRD;
            end else if (!find_ph_ff && idx == '0) begin
               // front missed; probe back
               idx_set  = cnt - 1'b1;
               idx_load = 1'b1;
               state_in = (cnt == CW'(1)) ? S_RSP : S_FIND;
               if (cnt == CW'(1)) begin
                  st_in = dle_pkg::ST_NOTFOUND;
               end
               find_ph_in = (cnt == CW'(1)) ? 1'b0 : 1'b0;
               if (cnt != CW'(1)) begin
                  tgt_in = '1; // marks back probe
               end
            end else if (!find_ph_ff) begin
               // back missed; scan middle from index one
               find_ph_in = 1'b1;
               idx_set    = CW'(1);
               idx_load   = 1'b1;
               state_in   = S_FIND;
            end else begin
               idx_inc  = 1'b1;
               state_in = S_FIND;
            end
         end
         S_RES: begin
            rd_en    = 1'b1;
            state_in = S_RESC;
         end
         S_RESC: begin
            res_cap = 1'b1;
            if (act_ff == dle_pkg::ACT_READ_AT) begin
               state_in = S_FRD;
            end else begin
               state_in = S_RMRD;
            end
         end
         S_RMRD: begin
            if (idx + 1'b1 >= cnt) begin
               cnt_dec  = 1'b1;
               state_in = S_FRD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx + 1'b1);
               state_in = S_RMWR;
            end
         end
         S_RMWR: begin
            wr_en    = 1'b1;
            idx_inc  = 1'b1;
            state_in = S_RMRD;
         end
         S_INRD: begin
            if (idx == tgt_ff) begin
               state_in = S_INPUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx - 1'b1);
               state_in = S_INWR;
            end
         end
         S_INWR: begin
            wr_en    = 1'b1;
            idx_dec  = 1'b1;
            state_in = S_INRD;
         end
         S_INPUT: begin
            wr_en      = 1'b1;
            wr_sel_val = 1'b1;
            cnt_inc    = 1'b1;
            state_in   = S_FRD;
         end
         S_FRD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = S_FCAP;
         end
         S_FCAP: begin
            front_cap = 1'b1;
            rd_en     = 1'b1;
            rd_addr   = AW'(cnt - 1'b1);
            state_in  = S_BCAP;
         end
         S_BCAP: begin
            back_cap = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

@@ sv/deque_list_engine_unit.sv @@
// deque_list_engine_unit: top level of the bounded ordered deque engine
// depends on dle_pkg, dle_ctrl and dle_datapath
//
//   channel   dir   ports                                         handshake
//   request   in    req_action, req_value, req_position           req_valid / req_stall
//   response  out   rsp_result_value, rsp_status, rsp_count,      rsp_valid / rsp_stall
//                   rsp_front_value, rsp_back_value
//
// one request at a time; a refused request goes from the decide state straight to its
// response, otherwise the time grows with each entry scanned or shifted, as every
// step goes through the entry memory, which has one read port and one write port.
// after the response is taken the sequencer returns to idle, where the next request is taken.
// reset is synchronous and clears count and sequencer; entries stay undefined.
// a stalled response holds until taken; no new request is taken meanwhile.
module deque_list_engine_unit #(
   parameter int DEPTH = dle_pkg::DEPTH_DEFAULT,
   parameter int WIDTH = dle_pkg::WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [3:0]              req_action,
   input  logic signed [WIDTH-1:0] req_value,
   input  logic [4:0]              req_position,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WIDTH-1:0] rsp_result_value,
   output logic [2:0]              rsp_status,
   output logic [4:0]              rsp_count,
   output logic signed [WIDTH-1:0] rsp_front_value,
   output logic signed [WIDTH-1:0] rsp_back_value
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          load, idx_load, idx_inc, idx_dec, rd_en, wr_en, wr_sel_val;
   logic          cnt_inc, cnt_dec, res_cap, res_clr, front_cap, back_cap;
   logic          rd_eq, rd_less;
   logic [CW-1:0] idx_set, idx, cnt;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [WIDTH-1:0] res, front, back;

   dle_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_position,
      .rsp_valid, .rsp_stall, .rsp_status, .idx, .cnt, .rd_eq, .rd_less,
      .load, .idx_set, .idx_load, .idx_inc, .idx_dec, .rd_en, .rd_addr,
      .wr_en, .wr_sel_val, .wr_addr, .cnt_inc, .cnt_dec, .res_cap, .res_clr,
      .front_cap, .back_cap
   );

   dle_datapath #(.DEPTH(DEPTH), .WIDTH(WIDTH), .AW(AW), .CW(CW)) u_dp (
      .clock, .reset, .load, .value(req_value), .idx_set, .idx_load, .idx_inc,
      .idx_dec, .rd_en, .rd_addr, .wr_en, .wr_sel_val, .wr_addr, .cnt_inc,
      .cnt_dec, .res_cap, .res_clr, .front_cap, .back_cap, .idx, .cnt,
      .rd_eq, .rd_less, .res, .front, .back
   );

   assign rsp_result_value = res;
   assign rsp_count        = 5'(cnt);
   assign rsp_front_value  = front;
   assign rsp_back_value   = back;
endmodule

@@ sv/dle_checker.sv @@
// dle_checker: port-level checks for deque_list_engine_unit, bound to the top
// depends on dle_pkg for status codes
module dle_checker #(
   parameter int WIDTH = dle_pkg::WIDTH_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [WIDTH-1:0] rsp_result_value,
   input logic [2:0]       rsp_status,
   input logic [4:0]       rsp_count
);
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dle_pkg::ST_OK |-> rsp_result_value == '0)
      else $error("error response carries a value");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken without going busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= dle_pkg::ST_NOTFOUND)
      else $error("bad status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count))
      else $error("stalled response dropped");
endmodule

bind deque_list_engine_unit dle_checker #(.WIDTH(WIDTH)) u_dle_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_result_value, .rsp_status, .rsp_count
);
